// ----- sv/imw_pkg.sv -----
package imw_pkg;

    localparam int DIRECT_REFS     = 4;
    localparam int REFS_PER_BLOCK  = 256;
    localparam int INODES          = 64;
    localparam int STORE_BLOCKS    = 64;

    localparam int SLOTS_PER_INODE = DIRECT_REFS + 2;
    localparam int INODE_WORDS     = INODES * SLOTS_PER_INODE;
    localparam int STORE_WORDS     = STORE_BLOCKS * REFS_PER_BLOCK;
    localparam int SINGLE_LIMIT    = DIRECT_REFS + REFS_PER_BLOCK;
    localparam int LB_LIMIT        = SINGLE_LIMIT + REFS_PER_BLOCK * REFS_PER_BLOCK;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int INO_W    = 6;
    localparam int SLOT_W   = 3;
    localparam int BLK_W    = 6;
    localparam int WORD_W   = 8;
    localparam int REF_W    = 32;
    localparam int LB_W     = 17;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 1;

    // derived internal widths
    localparam int INODE_AW = $clog2(INODE_WORDS);
    localparam int STORE_AW = $clog2(STORE_WORDS);
    localparam int WIDX_W   = $clog2(REFS_PER_BLOCK);
    localparam int SEL_W    = $clog2(SLOTS_PER_INODE);

    localparam logic [CMD_W-1:0] CMD_WRITE_SLOT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_WORD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_REF    = 1'd1;

    localparam logic [COUNT_W-1:0] INODE_COUNT_RESET = 7'd64;
    localparam logic [REF_W-1:0]   NULL_REF_RESET    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                inode_we;
        logic                inode_re;
        logic [INODE_AW-1:0] inode_addr;
        logic                store_we;
        logic                store_re;
        logic [STORE_AW-1:0] store_addr;
        logic [REF_W-1:0]    wdata;
    } t_mem_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    phys;
    } t_result;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [BLK_W-1:0] blk,
                                                       input logic [WIDX_W-1:0] idx);
        store_addr = STORE_AW'(blk) * STORE_AW'(REFS_PER_BLOCK) + STORE_AW'(idx);
    endfunction

    function automatic logic [INODE_AW-1:0] inode_addr(input logic [INO_W-1:0] ino,
                                                       input logic [SEL_W-1:0] sel);
        inode_addr = INODE_AW'(ino) * INODE_AW'(SLOTS_PER_INODE) + INODE_AW'(sel);
    endfunction

endpackage

// ----- sv/imw_ram.sv -----
module imw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/imw_walk.sv -----
module imw_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [imw_pkg::CMD_W-1:0]       i_cmd,
    input  logic [imw_pkg::INO_W-1:0]       i_inode_number,
    input  logic [imw_pkg::SLOT_W-1:0]      i_slot,
    input  logic [imw_pkg::BLK_W-1:0]       i_store_block,
    input  logic [imw_pkg::WORD_W-1:0]      i_word_index,
    input  logic [imw_pkg::REF_W-1:0]       i_value,
    input  logic [imw_pkg::LB_W-1:0]        i_logical_block,
    input  logic                            i_cfg_we,
    input  logic [imw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imw_pkg::REF_W-1:0]       i_cfg_data,
    input  logic [imw_pkg::REF_W-1:0]       i_inode_rdata,
    input  logic [imw_pkg::REF_W-1:0]       i_store_rdata,
    input  logic                            i_out_free,
    output logic                            o_busy,
    output imw_pkg::t_mem_req               o_req,
    output logic                            o_push,
    output imw_pkg::t_result                o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_WORD1,
        S_WORD2,
        S_HOLD
    } t_state;

    typedef enum logic [1:0] {
        K_DIRECT,
        K_SINGLE,
        K_DOUBLE
    } t_kind;

    t_state                          r_state, n_state;
    t_kind                           r_kind, n_kind;
    logic [imw_pkg::WIDX_W-1:0]      r_idx1, n_idx1;
    logic [imw_pkg::WIDX_W-1:0]      r_idx2, n_idx2;
    imw_pkg::t_result                r_res, n_res;
    logic [imw_pkg::COUNT_W-1:0]     r_inode_count;
    logic [imw_pkg::REF_W-1:0]       r_null_ref;

    imw_pkg::t_mem_req               req;
    imw_pkg::t_result                fin_res;
    logic                            finish;
    logic                            push;
    logic [imw_pkg::LB_W-1:0]        rel;
    logic [imw_pkg::SEL_W-1:0]       sel;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_idx1  = r_idx1;
        n_idx2  = r_idx2;
        n_res   = r_res;
        req     = '0;
        fin_res = '0;
        finish  = 1'b0;
        push    = 1'b0;
        rel     = i_logical_block - imw_pkg::LB_W'(imw_pkg::SINGLE_LIMIT);
        sel     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        imw_pkg::CMD_WRITE_SLOT: begin
                            if (int'(i_inode_number) < imw_pkg::INODES &&
                                int'(i_slot) < imw_pkg::SLOTS_PER_INODE) begin
                                req.inode_we   = 1'b1;
                                req.inode_addr = imw_pkg::inode_addr(i_inode_number,
                                                                     imw_pkg::SEL_W'(i_slot));
                                req.wdata      = i_value;
                            end
                            finish = 1'b1;
                        end
                        imw_pkg::CMD_WRITE_WORD: begin
                            if (int'(i_store_block) < imw_pkg::STORE_BLOCKS &&
                                int'(i_word_index) < imw_pkg::REFS_PER_BLOCK) begin
                                req.store_we   = 1'b1;
                                req.store_addr = imw_pkg::store_addr(
                                    i_store_block, imw_pkg::WIDX_W'(i_word_index));
                                req.wdata      = i_value;
                            end
                            finish = 1'b1;
                        end
                        imw_pkg::CMD_TRANSLATE: begin
                            if (imw_pkg::COUNT_W'(i_inode_number) >= r_inode_count ||
                                int'(i_inode_number) >= imw_pkg::INODES) begin
                                finish         = 1'b1;
                                fin_res.status = imw_pkg::ST_BAD_INODE;
                            end else if (int'(i_logical_block) >= imw_pkg::LB_LIMIT) begin
                                finish         = 1'b1;
                                fin_res.status = imw_pkg::ST_BAD_INDEX;
                            end else begin
                                if (int'(i_logical_block) < imw_pkg::DIRECT_REFS) begin
                                    sel    = imw_pkg::SEL_W'(i_logical_block);
                                    n_kind = K_DIRECT;
                                end else if (int'(i_logical_block) < imw_pkg::SINGLE_LIMIT) begin
                                    sel    = imw_pkg::SEL_W'(imw_pkg::DIRECT_REFS);
                                    n_kind = K_SINGLE;
                                    n_idx1 = imw_pkg::WIDX_W'(i_logical_block -
                                             imw_pkg::LB_W'(imw_pkg::DIRECT_REFS));
                                end else begin
                                    sel    = imw_pkg::SEL_W'(imw_pkg::DIRECT_REFS + 1);
                                    n_kind = K_DOUBLE;
                                    n_idx1 = imw_pkg::WIDX_W'(rel / imw_pkg::REFS_PER_BLOCK);
                                    n_idx2 = imw_pkg::WIDX_W'(rel % imw_pkg::REFS_PER_BLOCK);
                                end
                                req.inode_re   = 1'b1;
                                req.inode_addr = imw_pkg::inode_addr(i_inode_number, sel);
                                n_state        = S_SLOT;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SLOT: begin
                if (r_kind == K_DIRECT) begin
                    finish       = 1'b1;
                    fin_res.phys = i_inode_rdata;
                end else if (i_inode_rdata == r_null_ref) begin
                    finish       = 1'b1;
                    fin_res.phys = r_null_ref;
                end else if (i_inode_rdata >= imw_pkg::REF_W'(imw_pkg::STORE_BLOCKS)) begin
                    finish         = 1'b1;
                    fin_res.status = imw_pkg::ST_OUTSIDE;
                end else begin
                    req.store_re   = 1'b1;
                    req.store_addr = imw_pkg::store_addr(
                        i_inode_rdata[imw_pkg::BLK_W-1:0], r_idx1);
                    n_state        = S_WORD1;
                end
            end
            S_WORD1: begin
                if (r_kind == K_SINGLE) begin
                    finish       = 1'b1;
                    fin_res.phys = i_store_rdata;
                end else if (i_store_rdata == r_null_ref) begin
                    finish       = 1'b1;
                    fin_res.phys = r_null_ref;
                end else if (i_store_rdata >= imw_pkg::REF_W'(imw_pkg::STORE_BLOCKS)) begin
                    finish         = 1'b1;
                    fin_res.status = imw_pkg::ST_OUTSIDE;
                end else begin
                    req.store_re   = 1'b1;
                    req.store_addr = imw_pkg::store_addr(
                        i_store_rdata[imw_pkg::BLK_W-1:0], r_idx2);
                    n_state        = S_WORD2;
                end
            end
            S_WORD2: begin
                finish       = 1'b1;
                fin_res.phys = i_store_rdata;
            end
            S_HOLD: begin
                // result parked until the output register frees up
                if (i_out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_res = fin_res;
            if (i_out_free) begin
                push    = 1'b1;
                n_state = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_inode_count <= imw_pkg::INODE_COUNT_RESET;
            r_null_ref    <= imw_pkg::NULL_REF_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    imw_pkg::CFG_INODE_COUNT: r_inode_count <= i_cfg_data[imw_pkg::COUNT_W-1:0];
                    imw_pkg::CFG_NULL_REF:    r_null_ref    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_kind <= n_kind;
        r_idx1 <= n_idx1;
        r_idx2 <= n_idx2;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_req    = req;
    assign o_push   = push;
    assign o_result = (r_state == S_HOLD) ? r_res : fin_res;

endmodule

// ----- sv/inode_block_map_walker.sv -----
// Channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------------
// command   | in        | i_valid / o_stall    | i_cmd, i_inode_number, i_slot, i_store_block,
//           |           |                      | i_word_index, i_value, i_logical_block
// result    | out       | o_valid / i_stall    | o_status, o_physical_block
// config    | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One command at a time. Writes, no-ops and rejected translates finish in the cycle of
// transfer; a translate reads the slot memory, then one word of the reference store (single
// indirect) or two dependent words (double indirect), each read waiting on the one before.
// Reset is synchronous and clears control and the two registers; memories are not cleared.
// A result waits in the output register while i_stall is high; the next command is taken
// meanwhile and its result is held inside until the output register drains.
module inode_block_map_walker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [imw_pkg::CMD_W-1:0]          i_cmd,
    input  logic [imw_pkg::INO_W-1:0]          i_inode_number,
    input  logic [imw_pkg::SLOT_W-1:0]         i_slot,
    input  logic [imw_pkg::BLK_W-1:0]          i_store_block,
    input  logic [imw_pkg::WORD_W-1:0]         i_word_index,
    input  logic [imw_pkg::REF_W-1:0]          i_value,
    input  logic [imw_pkg::LB_W-1:0]           i_logical_block,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [imw_pkg::STATUS_W-1:0]       o_status,
    output logic [imw_pkg::REF_W-1:0]          o_physical_block,
    input  logic                               i_cfg_we,
    input  logic [imw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [imw_pkg::REF_W-1:0]          i_cfg_data
);

    imw_pkg::t_mem_req               req;
    imw_pkg::t_result                result;
    logic                            push;
    logic                            busy;
    logic                            out_free;
    logic [imw_pkg::REF_W-1:0]       inode_rdata;
    logic [imw_pkg::REF_W-1:0]       store_rdata;

    logic                            r_out_valid;
    imw_pkg::t_result                r_out;

    assign out_free = !r_out_valid || !i_stall;

    imw_walk u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_cmd           (i_cmd),
        .i_inode_number  (i_inode_number),
        .i_slot          (i_slot),
        .i_store_block   (i_store_block),
        .i_word_index    (i_word_index),
        .i_value         (i_value),
        .i_logical_block (i_logical_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_inode_rdata   (inode_rdata),
        .i_store_rdata   (store_rdata),
        .i_out_free      (out_free),
        .o_busy          (busy),
        .o_req           (req),
        .o_push          (push),
        .o_result        (result)
    );

    imw_ram #(
        .WIDTH (imw_pkg::REF_W),
        .DEPTH (imw_pkg::INODE_WORDS)
    ) u_inode_ram (
        .i_clk   (i_clk),
        .i_we    (req.inode_we),
        .i_waddr (req.inode_addr),
        .i_wdata (req.wdata),
        .i_re    (req.inode_re),
        .i_raddr (req.inode_addr),
        .o_rdata (inode_rdata)
    );

    imw_ram #(
        .WIDTH (imw_pkg::REF_W),
        .DEPTH (imw_pkg::STORE_WORDS)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (req.store_we),
        .i_waddr (req.store_addr),
        .i_wdata (req.wdata),
        .i_re    (req.store_re),
        .i_raddr (req.store_addr),
        .o_rdata (store_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            r_out <= result;
        end
    end

    assign o_stall          = busy;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_physical_block = r_out.phys;

`ifndef SYNTHESIS
    a_push_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed over a pending transfer");

    a_one_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({req.inode_we, req.inode_re, req.store_we, req.store_re}))
        else $error("more than one memory access in a cycle");

    a_store_read_after_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.store_re |-> busy)
        else $error("store read issued outside a walk");

    a_walk_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !push) |=> busy)
        else $error("accepted command dropped without result");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
